[src/spi_dac_waveform_generator_unit_defines.svh]
// assertion macros for the waveform generator checker
`ifndef SPI_DAC_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define SPI_DAC_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

// property checked at every clock edge outside reset
`define SDWG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdwg check failed");

// implication checked on the following clock edge
`define SDWG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdwg check failed");

`endif

[src/sdwg_pkg.sv]
// shared types, codes, constants and sine table builder
`default_nettype none

package sdwg_pkg;

    localparam int TABLE_POINTS_DEF = 512;

    localparam int CODE_W   = 12;
    localparam int VALUE_W  = 16;
    localparam int CMD_W    = 3;
    localparam int SRC_W    = 2;
    localparam int FRAME_W  = 16;
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 20;
    localparam int PDB_W    = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int ROM_MAG_W  = 15;
    localparam int PROD_W     = CODE_W + ROM_MAG_W;
    localparam int DIV_STEPS  = CODE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CODE_W-1:0]  CODE_MAX        = 12'd4095;
    localparam logic [VALUE_W-1:0] DEFAULT_VREF_MV = 16'd3300;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_CODE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_VOLT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_DC     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POWER_DOWN = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POWER_UP   = 3'd5;

    // result source codes
    localparam logic [SRC_W-1:0] SRC_SINE       = 2'd0;
    localparam logic [SRC_W-1:0] SRC_PULSE      = 2'd1;
    localparam logic [SRC_W-1:0] SRC_DIRECT     = 2'd2;
    localparam logic [SRC_W-1:0] SRC_POWER_DOWN = 2'd3;

    // waveform modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WAVE_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE_MV   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VREF_MV        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_TICKS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POWERDOWN_BITS = 3'd4;

    // angle constants in q2.30
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic mul;
        logic emit;
    } sdwg_cmd_t;

    typedef struct packed {
        logic result;
        logic need_div;
        logic sine;
        logic div_last;
        logic out_free;
    } sdwg_status_t;

    // table entry {negative, magnitude q15} for angle x in q2.30, elaboration only
    function automatic logic [ROM_MAG_W:0] sine_entry(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic        neg;
        logic        sub;
        int          k;
        x   = x_in;
        neg = 1'b0;
        sub = 1'b1;
        if (x >= PI_Q30)
        begin
            neg = 1'b1;
            x   = x - PI_Q30;
        end
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        t = x;
        s = x;
        for (k = 1; k <= 8; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (k)
                1:       t = t / 64'd6;
                2:       t = t / 64'd20;
                3:       t = t / 64'd42;
                4:       t = t / 64'd72;
                5:       t = t / 64'd110;
                6:       t = t / 64'd156;
                7:       t = t / 64'd210;
                default: t = t / 64'd272;
            endcase
            if (sub)
                s = (s >= t) ? s - t : 64'd0;
            else
                s = s + t;
            sub = !sub;
        end
        r = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return {neg, r[ROM_MAG_W-1:0]};
    endfunction

endpackage

`default_nettype wire

[src/sdwg_div.sv]
// restoring divider for millivolt to code conversion, one quotient bit a cycle while step is high
`default_nettype none

module sdwg_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          step,
    input  wire logic [sdwg_pkg::VALUE_W-1:0]  numer,
    input  wire logic [sdwg_pkg::VALUE_W-1:0]  denom,
    output logic      [sdwg_pkg::CODE_W-1:0]   quot,
    output logic                               last
);
    import sdwg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0]   rem_reg;
    logic [VALUE_W-1:0]   denom_reg;
    logic [CODE_W-1:0]    quot_reg;
    logic                 sat_reg;

    logic [VALUE_W:0]     rem_shift;
    logic                 ge;
    logic [VALUE_W-1:0]   rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        ge        = rem_shift >= {1'b0, denom_reg};
        rem_next  = ge ? VALUE_W'(rem_shift - {1'b0, denom_reg}) : rem_shift[VALUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= '0;
        else if (step)
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
    end

    // quotient at or above full scale saturates
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg   <= numer >= denom;
            rem_reg   <= numer;
            denom_reg <= denom;
            quot_reg  <= '0;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[CODE_W-2:0], ge};
        end
    end

    assign last = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign quot = sat_reg ? CODE_MAX : quot_reg;

endmodule

`default_nettype wire

[src/sdwg_ctrl.sv]
// sequencing state machine
`default_nettype none

module sdwg_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire sdwg_pkg::sdwg_status_t  status,
    output sdwg_pkg::sdwg_cmd_t          cmd
);
    import sdwg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!status.result)
                    state_next = S_IDLE;
                else if (status.need_div)
                    state_next = S_DIV;
                else
                    state_next = S_EMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = status.sine ? S_MUL : S_EMIT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[src/sdwg_dp.sv]
// datapath: registers, waveform state, sine table, divider, multiplier, output slot
`default_nettype none

module sdwg_dp #(
    parameter int TABLE_POINTS = sdwg_pkg::TABLE_POINTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [sdwg_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [sdwg_pkg::CMD_W-1:0]        s_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [sdwg_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [sdwg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire sdwg_pkg::sdwg_cmd_t               cmd,
    output sdwg_pkg::sdwg_status_t                 status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sdwg_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic      [sdwg_pkg::SRC_W-1:0]        m_tuser
);
    import sdwg_pkg::*;

    localparam int PHASE_W = $clog2(TABLE_POINTS);

    // configuration registers
    logic [MODE_W-1:0]   wave_mode_reg;
    logic [VALUE_W-1:0]  amplitude_reg;
    logic [VALUE_W-1:0]  vref_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PDB_W-1:0]    pd_bits_reg;

    // waveform state
    logic [PERIOD_W-1:0] tick_count_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic                pulse_high_next_reg;
    logic                halted_reg;

    // item and intermediate values
    logic [CMD_W-1:0]     item_cmd_reg;
    logic [VALUE_W-1:0]   item_value_reg;
    logic                 pulse_hi_reg;
    logic [ROM_MAG_W:0]   rom_q_reg;
    logic [PROD_W-1:0]    prod_reg;

    // output slot
    logic                 out_valid_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [SRC_W-1:0]     src_reg;

    logic                 restart;
    logic                 wave_on;
    logic                 is_sine;
    logic [PERIOD_W-1:0]  per_eff;
    logic [PERIOD_W-1:0]  tick_count_next;
    logic                 is_tick;
    logic                 fire;
    logic [PHASE_W-1:0]   phase_next;
    logic                 div_start;
    logic [VALUE_W-1:0]   div_numer;
    logic [VALUE_W-1:0]   vref_eff;
    logic [CODE_W-1:0]    div_quot;
    logic                 div_last;
    logic [CODE_W-1:0]    mag;
    logic [CODE_W:0]      sum_up;
    logic [CODE_W-1:0]    sine_code;
    logic [CODE_W-1:0]    emit_code;
    logic [PDB_W-1:0]     emit_bits;
    logic [SRC_W-1:0]     emit_src;

    // sine table built at elaboration
    logic [ROM_MAG_W:0] sine_rom [TABLE_POINTS];

    for (genvar g = 0; g < TABLE_POINTS; g++)
    begin : g_rom
        localparam logic [63:0] XG = (64'(g) * TWO_PI_Q30) / 64'(TABLE_POINTS);
        localparam logic [ROM_MAG_W:0] ENTRY = sine_entry(XG);
        assign sine_rom[g] = ENTRY;
    end

    assign restart = cfg_we && (cfg_index <= REG_POWERDOWN_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg <= MODE_OFF;
            amplitude_reg <= 16'd2000;
            vref_reg      <= DEFAULT_VREF_MV;
            period_reg    <= 20'd1000;
            pd_bits_reg   <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVE_MODE:      wave_mode_reg <= cfg_data[MODE_W-1:0];
                REG_AMPLITUDE_MV:   amplitude_reg <= cfg_data[VALUE_W-1:0];
                REG_VREF_MV:        vref_reg      <= cfg_data[VALUE_W-1:0];
                REG_PERIOD_TICKS:   period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_POWERDOWN_BITS: pd_bits_reg   <= cfg_data[PDB_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        is_tick         = item_cmd_reg == CMD_TICK;
        is_sine         = wave_mode_reg == MODE_SINE;
        wave_on         = !halted_reg && (is_sine || wave_mode_reg == MODE_PULSE);
        per_eff         = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        tick_count_next = tick_count_reg + PERIOD_W'(1);
        fire            = is_tick && wave_on && (tick_count_next >= per_eff);
        phase_next      = (phase_reg == PHASE_W'(TABLE_POINTS - 1)) ?
                          '0 : phase_reg + PHASE_W'(1);
        vref_eff        = (vref_reg == '0) ? DEFAULT_VREF_MV : vref_reg;
        div_numer       = item_value_reg;
        if (is_tick)
            div_numer = is_sine ? {1'b0, amplitude_reg[VALUE_W-1:1]} : amplitude_reg;
    end

    always_comb
    begin
        status          = '0;
        status.sine     = is_tick && is_sine;
        status.div_last = div_last;
        status.out_free = !out_valid_reg || m_tready;
        case (item_cmd_reg)
            CMD_TICK:
            begin
                status.result   = fire;
                status.need_div = fire && (is_sine || pulse_high_next_reg);
            end
            CMD_WRITE_CODE, CMD_POWER_DOWN, CMD_POWER_UP:
                status.result = 1'b1;
            CMD_WRITE_VOLT, CMD_SET_DC:
            begin
                status.result   = 1'b1;
                status.need_div = 1'b1;
            end
            default:
                status.result = 1'b0;
        endcase
    end

    assign div_start = cmd.eval && status.need_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg      <= '0;
            phase_reg           <= '0;
            pulse_high_next_reg <= 1'b1;
            halted_reg          <= 1'b0;
        end
        else if (restart)
        begin
            tick_count_reg      <= '0;
            phase_reg           <= '0;
            pulse_high_next_reg <= 1'b1;
            halted_reg          <= 1'b0;
        end
        else if (cmd.eval)
        begin
            if (is_tick && wave_on)
            begin
                if (fire)
                begin
                    tick_count_reg <= '0;
                    if (is_sine)
                        phase_reg <= phase_next;
                    else
                        pulse_high_next_reg <= !pulse_high_next_reg;
                end
                else
                begin
                    tick_count_reg <= tick_count_next;
                end
            end
            if (item_cmd_reg == CMD_SET_DC || item_cmd_reg == CMD_POWER_DOWN)
                halted_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg   <= s_tuser;
            item_value_reg <= s_tdata;
        end
        if (cmd.eval)
        begin
            rom_q_reg    <= sine_rom[phase_reg];
            pulse_hi_reg <= pulse_high_next_reg;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(div_quot) * PROD_W'(rom_q_reg[ROM_MAG_W-1:0]);
    end

    sdwg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .step  (cmd.div_step),
        .numer (div_numer),
        .denom (vref_eff),
        .quot  (div_quot),
        .last  (div_last)
    );

    // center plus or minus scaled table value, clamped
    always_comb
    begin
        mag    = prod_reg[PROD_W-1:ROM_MAG_W];
        sum_up = {1'b0, div_quot} + {1'b0, mag};
        if (rom_q_reg[ROM_MAG_W])
            sine_code = (mag > div_quot) ? '0 : div_quot - mag;
        else
            sine_code = sum_up[CODE_W] ? CODE_MAX : sum_up[CODE_W-1:0];
    end

    always_comb
    begin
        emit_bits = '0;
        emit_code = '0;
        emit_src  = SRC_DIRECT;
        case (item_cmd_reg)
            CMD_TICK:
            begin
                if (is_sine)
                begin
                    emit_code = sine_code;
                    emit_src  = SRC_SINE;
                end
                else
                begin
                    emit_code = pulse_hi_reg ? div_quot : '0;
                    emit_src  = SRC_PULSE;
                end
            end
            CMD_WRITE_CODE:
                emit_code = (item_value_reg > VALUE_W'(CODE_MAX)) ?
                            CODE_MAX : item_value_reg[CODE_W-1:0];
            CMD_WRITE_VOLT, CMD_SET_DC:
                emit_code = div_quot;
            CMD_POWER_DOWN:
            begin
                emit_bits = pd_bits_reg;
                emit_src  = SRC_POWER_DOWN;
            end
            default:
                emit_code = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            frame_reg <= {emit_bits, emit_code, 2'b00};
            code_reg  <= emit_code;
            src_reg   <= emit_src;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - FRAME_W - CODE_W){1'b0}}, code_reg, frame_reg};
    assign m_tuser  = src_reg;

endmodule

`default_nettype wire

[src/spi_dac_waveform_generator_unit.sv]
// top level: dac frame builder for sine, pulse and direct commands
// sequence: idle accepts an item, evaluate, then emit for direct codes, power down and power up;
//   voltage, dc and pulse-high samples pass through the divider, sine samples also the multiplier
// throughput: one item at a time, the next is accepted only once the controller is back in idle;
//   the shared iterative divider sets the worst case
// reset: rst_n is asynchronous, active low; configuration and state registers return to defaults, no clearing pass
`default_nettype none

module spi_dac_waveform_generator_unit #(
    parameter int TABLE_POINTS = sdwg_pkg::TABLE_POINTS_DEF   // sine table length
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input item stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sdwg_pkg::IN_DATA_W-1:0]    s_tdata,    // [15:0] value
    input  wire logic [sdwg_pkg::CMD_W-1:0]        s_tuser,    // [2:0] command
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sdwg_pkg::OUT_DATA_W-1:0]   m_tdata,    // [15:0] frame, [27:16] code
    output logic      [sdwg_pkg::SRC_W-1:0]        m_tuser,    // [1:0] source
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sdwg_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [sdwg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sdwg_pkg::*;

    sdwg_cmd_t    cmd;
    sdwg_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // controller: idle, evaluate, divide, multiply, emit
    sdwg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: config, tick counter, phase, table, divider, multiplier, output slot
    // the output slot lets the next transaction start while a result waits
    sdwg_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[src/sdwg_checker.sv]
// port-level checks for the waveform generator, bound to the top level
`default_nettype none
`include "spi_dac_waveform_generator_unit_defines.svh"

module sdwg_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [sdwg_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire logic [sdwg_pkg::SRC_W-1:0]        m_tuser
);
    import sdwg_pkg::*;

    // stalled result stays offered
    `SDWG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // code field matches the code inside the frame, the low frame bits and the top bits are zero
    `SDWG_ASSERT(a_frame_code, m_tvalid |-> (m_tdata[13:2] == m_tdata[27:16]) && (m_tdata[1:0] == 2'b00) && (m_tdata[31:28] == 4'b0000))

    // only power down frames carry mode bits, and they carry code zero
    `SDWG_ASSERT(a_mode_bits, m_tvalid |-> ((m_tuser == SRC_POWER_DOWN) ? (m_tdata[27:16] == '0) : (m_tdata[15:14] == 2'b00)))

    // one transaction in work at a time
    `SDWG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind spi_dac_waveform_generator_unit sdwg_checker u_sdwg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
